// File: rtl/fir45_pkg.sv
// Shared constants, types and the coefficient table of the 45-tap low-pass FIR.
// No dependencies; imported by every module of the filter.
`default_nettype none
package fir45_pkg;

   localparam int TAP_COUNT_DEF      = 45;
   localparam int COEF_FRAC_BITS_DEF = 15;
   localparam int MAX_TAPS           = 128;
   localparam int SAMPLE_W           = 16;
   localparam int COEF_W             = 16;
   localparam int PROD_W             = SAMPLE_W + COEF_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // per-item control broadcast to every tap cell
   typedef struct packed {
      logic advance;   // an item is accepted this cycle
      logic clear;     // that item ends its block: drop the history after it
   } fir45_ctrl_type;

   // Q1.15 coefficients; taps past the table are zero
   function automatic coef_type coef_at(input int idx);
      coef_type c;
      unique case (idx)
         0:  c = -16'sd60;
         1:  c = -16'sd87;
         2:  c = 16'sd0;
         3:  c = 16'sd103;
         4:  c = 16'sd85;
         5:  c = -16'sd136;
         6:  c = -16'sd505;
         7:  c = -16'sd821;
         8:  c = -16'sd835;
         9:  c = -16'sd386;
         10: c = 16'sd456;
         11: c = 16'sd1378;
         12: c = 16'sd1929;
         13: c = 16'sd1739;
         14: c = 16'sd729;
         15: c = -16'sd790;
         16: c = -16'sd2213;
         17: c = -16'sd2894;
         18: c = -16'sd2449;
         19: c = -16'sd969;
         20: c = 16'sd993;
         21: c = 16'sd2638;
         22: c = 16'sd3277;
         23: c = 16'sd2638;
         24: c = 16'sd993;
         25: c = -16'sd969;
         26: c = -16'sd2449;
         27: c = -16'sd2894;
         28: c = -16'sd2213;
         29: c = -16'sd790;
         30: c = 16'sd729;
         31: c = 16'sd1739;
         32: c = 16'sd1929;
         33: c = 16'sd1378;
         34: c = 16'sd456;
         35: c = -16'sd386;
         36: c = -16'sd835;
         37: c = -16'sd821;
         38: c = -16'sd505;
         39: c = -16'sd136;
         40: c = 16'sd85;
         41: c = 16'sd103;
         42: c = 16'sd0;
         43: c = -16'sd87;
         44: c = -16'sd60;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/fir45_tap_cell.sv
// One cell of the transposed-form tap chain: multiply by a fixed coefficient,
// add the neighbor's partial sum, hold the result. Depends on fir45_pkg.
`default_nettype none
module fir45_tap_cell #(
   parameter int ACC_W     = 40,
   parameter int TAP_INDEX = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fir45_pkg::fir45_ctrl_type ctrl,
   input  wire fir45_pkg::sample_type     sample,
   input  wire logic signed [ACC_W-1:0]   partial_in,
   output logic signed [ACC_W-1:0]        partial_out
);
   import fir45_pkg::*;

   localparam coef_type COEF = coef_at(TAP_INDEX);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  partial_ff;
   logic signed [ACC_W-1:0]  partial_in_sum;

   assign prod           = COEF * sample;
   assign partial_in_sum = ACC_W'(prod) + partial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
      end else if (ctrl.advance) begin
         // end of block: everything older than this item is gone
         partial_ff <= ctrl.clear ? '0 : partial_in_sum;
      end
   end

   assign partial_out = partial_ff;

endmodule
`default_nettype wire

// File: rtl/fir45_out_stage.sv
// Output register of the filter: holds the full-width sum, then truncates it
// toward zero and saturates it to 16 bits. Depends on fir45_pkg.
`default_nettype none
module fir45_out_stage #(
   parameter int ACC_W          = 40,
   parameter int COEF_FRAC_BITS = 15
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fir45_pkg::fir45_ctrl_type ctrl,
   input  wire logic signed [ACC_W-1:0]   acc,
   output logic                           in_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output fir45_pkg::sample_type          rsp_sample_out,
   output logic                           rsp_clipped,
   output logic                           rsp_last_out
);
   import fir45_pkg::*;

   localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
   localparam logic signed [ACC_W-1:0] NO_BIAS = ACC_W'(0);
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-32768);

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    last_ff;
   logic signed [ACC_W-1:0] trunc;

   assign in_ready     = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = ctrl.advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         acc_ff  <= acc;
         last_ff <= ctrl.clear;
      end
   end

   // bias negative sums so the arithmetic shift rounds toward zero
   assign trunc = (acc_ff + (acc_ff[ACC_W-1] ? BIAS : NO_BIAS)) >>> COEF_FRAC_BITS;

   always_comb begin
      rsp_clipped    = 1'b0;
      rsp_sample_out = SAMPLE_W'(trunc);
      priority if (trunc > OUT_MAX) begin
         rsp_clipped    = 1'b1;
         rsp_sample_out = SAMPLE_W'(OUT_MAX);
      end else if (trunc < OUT_MIN) begin
         rsp_clipped    = 1'b1;
         rsp_sample_out = SAMPLE_W'(OUT_MIN);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_last_out = last_ff;

endmodule
`default_nettype wire

// File: rtl/fir_lowpass_45tap_top.sv
// Top level of the 45-tap low-pass FIR: coefficient-0 product, chain of tap
// cells and output stage. Depends on fir45_pkg, fir45_tap_cell, fir45_out_stage.
//
// Usage:
//   Input channel req_*: one signed 16-bit sample per item plus a last-of-block
//   flag. An item is taken at a rising edge with req_valid high and req_stall
//   low. Output channel rsp_*: one filtered sample per item, with a clip flag
//   and a copy of the last-of-block flag, taken when rsp_valid is high and
//   rsp_stall is low.
//   Latency: the result shows on rsp_* in the cycle after its item is taken.
//   Throughput: one item per cycle unless stalled. The transposed tap chain
//   does all taps of an item at once, one 16x16 multiply and add per cell,
//   and the single output register is refilled in the same cycle it is emptied.
//   Stall: while the output register holds an untaken result and rsp_stall is
//   high, req_stall is high and the chain holds its partial sums.
//   Reset (synchronous, active high): all partial sums clear to zero, so the
//   history reads as zero samples; no result is pending.
//   After an item flagged last of block, the history clears to zero.
`default_nettype none
module fir_lowpass_45tap_top #(
   parameter int TAP_COUNT      = fir45_pkg::TAP_COUNT_DEF,
   parameter int COEF_FRAC_BITS = fir45_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fir45_pkg::sample_type req_sample_in,
   input  wire logic                  req_last_in_block,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output fir45_pkg::sample_type      rsp_sample_out,
   output logic                       rsp_clipped,
   output logic                       rsp_last_out
);
   import fir45_pkg::*;

   localparam int       ACC_W = PROD_W + $clog2(TAP_COUNT + 1);
   localparam coef_type COEF0 = coef_at(0);

   fir45_ctrl_type           ctrl;
   logic                     in_ready;
   logic signed [PROD_W-1:0] head_prod;
   logic signed [ACC_W-1:0]  head_acc;
   logic signed [ACC_W-1:0]  chain [1:TAP_COUNT];

   assign req_stall    = ~in_ready;
   assign ctrl.advance = req_valid & in_ready;
   assign ctrl.clear   = req_last_in_block;

   // nothing feeds the far end of the chain
   assign chain[TAP_COUNT] = '0;

   for (genvar k = 1; k < TAP_COUNT; k++) begin : g_tap
      fir45_tap_cell #(
         .ACC_W     (ACC_W),
         .TAP_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample      (req_sample_in),
         .partial_in  (chain[k+1]),
         .partial_out (chain[k])
      );
   end

   assign head_prod = COEF0 * req_sample_in;
   assign head_acc  = ACC_W'(head_prod) + chain[1];

   fir45_out_stage #(
      .ACC_W          (ACC_W),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_out (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .acc            (head_acc),
      .in_ready       (in_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .rsp_last_out   (rsp_last_out)
   );

endmodule
`default_nettype wire
